// ===== rtl/grmc_pkg.sv =====
// Shared types, constants and saturating step helpers for the gamepad-to-MIDI block.
`default_nettype none

package grmc_pkg;

  localparam int unsigned REPORT_BYTES = 7;
  localparam int unsigned PKT_SLOTS    = 3;

  localparam logic [3:0] CIN_CTRL_CHANGE = 4'hB;
  localparam logic [3:0] CIN_PROG_CHANGE = 4'hC;
  localparam logic [7:0] STATUS_CTRL     = 8'hB0;
  localparam logic [7:0] STATUS_PROG     = 8'hC0;
  localparam logic [7:0] AXIS_LOW        = 8'h00;
  localparam logic [7:0] AXIS_HIGH       = 8'hFF;
  localparam logic [7:0] PAD_RESET       = 8'h0D;
  localparam logic [6:0] VALUE_MAX       = 7'd127;

  // Button positions (bit index = button id - 1)
  localparam int unsigned BTN_CCH_DOWN  = 0;
  localparam int unsigned BTN_CCH_UP    = 1;
  localparam int unsigned BTN_CNUM_UP   = 2;
  localparam int unsigned BTN_CNUM_DOWN = 3;
  localparam int unsigned BTN_PCH_DOWN  = 4;
  localparam int unsigned BTN_PCH_UP    = 5;
  localparam int unsigned BTN_PVAL_DOWN = 6;
  localparam int unsigned BTN_PVAL_UP   = 7;
  localparam int unsigned BTN_PROG_CLR  = 8;
  localparam int unsigned BTN_CTRL_CLR  = 9;

  typedef struct packed {
    logic [7:0] high_buttons;
    logic [7:0] hat_and_low_buttons;
    logic [7:0] report_byte4;
    logic [7:0] report_byte3;
    logic [7:0] report_byte2;
    logic [7:0] report_byte1;
    logic [7:0] axis_x;
  } report_t;

  typedef struct packed {
    logic [6:0] data_second;
    logic [6:0] data_first;
    logic [7:0] status_byte;
    logic [3:0] cable_code;
  } packet_t;

  // Slot 0 control change, slot 1 and 2 program changes, in emit order
  typedef struct packed {
    logic [PKT_SLOTS-1:0]         valid;
    packet_t [PKT_SLOTS-1:0]      pkt;
  } pkt_set_t;

  function automatic logic [6:0] sat_up(input logic [6:0] v);
    return (v == VALUE_MAX) ? VALUE_MAX : v + 7'd1;
  endfunction

  function automatic logic [6:0] sat_down(input logic [6:0] v);
    return (v == 7'd0) ? 7'd0 : v - 7'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gamepad_report_to_midi_controller_unit.sv =====
// Top level: input register, controller update and packet output register.
`default_nettype none

// Gamepad HID report in, USB-MIDI event packets out. Each accepted item is one
// report; it is registered in the input register, then the controller state is
// updated and zero to three packets (control change first, then program
// changes) are loaded into the output register once that register is free. The
// output register sends one packet per cycle while m_axis_tready is high, with
// tlast on the final packet of the report. A report that makes packets waits in
// the input register while those of the previous report drain through the single
// packet output port. A new report is taken while the last packet of the previous
// one is being sent.
module gamepad_report_to_midi_controller_unit #(
  parameter int unsigned PAD_BYTES    = 5,
  parameter int unsigned BUTTON_COUNT = 12
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // axis_x, report_byte1..4, hat_and_low_buttons, high_buttons (8 bits each)
  input  wire  [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // cable_code[3:0], status_byte[11:4], data_first[18:12], data_second[25:19], zeros
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic               in_valid_q;
  grmc_pkg::report_t  in_item_q;
  grmc_pkg::pkt_set_t pkts;
  grmc_pkg::packet_t  out_pkt;
  logic               queue_free;
  logic               advance;
  logic               load;

  assign advance       = in_valid_q && ((pkts.valid == '0) || queue_free);
  assign load          = advance && (pkts.valid != '0);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Hold the item until its packets are in the output register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= grmc_pkg::report_t'(s_axis_tdata);
    end
  end

  grmc_step #(
    .PAD_BYTES   (PAD_BYTES),
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .report_i (in_item_q),
    .advance_i(advance),
    .pkts_o   (pkts)
  );

  grmc_pkt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .pkts_i  (pkts),
    .free_o  (queue_free),
    .tvalid_o(m_axis_tvalid),
    .tready_i(m_axis_tready),
    .pkt_o   (out_pkt),
    .tlast_o (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_pkt};

endmodule

`default_nettype wire

// ===== rtl/grmc_step.sv =====
// Controller state and the single-pass update that turns one report into packets.
`default_nettype none

module grmc_step #(
  parameter int unsigned PAD_BYTES    = 5,
  parameter int unsigned BUTTON_COUNT = 12
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  grmc_pkg::report_t     report_i,
  input  wire                   advance_i,
  output grmc_pkg::pkt_set_t    pkts_o
);

  logic [7:0] pad_q [PAD_BYTES];
  logic [BUTTON_COUNT-1:0] buttons_q;
  logic [6:0] pch_q, pval_q, cch_q, cnum_q, cval_q;
  logic [6:0] pch_d, pval_d, cch_d, cnum_d, cval_d;

  logic [7:0] in_bytes [grmc_pkg::REPORT_BYTES];
  logic differs;
  logic cc_fire;
  logic [11:0] btn_raw;
  logic [BUTTON_COUNT-1:0] buttons;
  logic [BUTTON_COUNT-1:0] pressed;
  logic [6:0] cval_step, cch_mid, cnum_mid, pch_mid, pval_dn, pval_up;

  assign in_bytes[0] = report_i.axis_x;
  assign in_bytes[1] = report_i.report_byte1;
  assign in_bytes[2] = report_i.report_byte2;
  assign in_bytes[3] = report_i.report_byte3;
  assign in_bytes[4] = report_i.report_byte4;
  assign in_bytes[5] = report_i.hat_and_low_buttons;
  assign in_bytes[6] = report_i.high_buttons;

  always_comb begin
    differs = 1'b0;
    for (int i = 0; i < PAD_BYTES; i++) begin
      if (in_bytes[i] != pad_q[i]) begin
        differs = 1'b1;
      end
    end
  end

  assign cc_fire = differs && (report_i.axis_x == grmc_pkg::AXIS_LOW ||
                               report_i.axis_x == grmc_pkg::AXIS_HIGH);

  assign btn_raw = {report_i.high_buttons, report_i.hat_and_low_buttons[7:4]};
  assign buttons = btn_raw[BUTTON_COUNT-1:0];
  assign pressed = buttons & ~buttons_q;

  always_comb begin
    cval_step = cval_q;
    if (cc_fire) begin
      cval_step = (report_i.axis_x == grmc_pkg::AXIS_LOW) ? grmc_pkg::sat_down(cval_q)
                                                          : grmc_pkg::sat_up(cval_q);
    end

    cch_mid = pressed[grmc_pkg::BTN_CCH_DOWN] ? grmc_pkg::sat_down(cch_q) : cch_q;
    cch_mid = pressed[grmc_pkg::BTN_CCH_UP] ? grmc_pkg::sat_up(cch_mid) : cch_mid;
    cnum_mid = pressed[grmc_pkg::BTN_CNUM_UP] ? grmc_pkg::sat_up(cnum_q) : cnum_q;
    cnum_mid = pressed[grmc_pkg::BTN_CNUM_DOWN] ? grmc_pkg::sat_down(cnum_mid) : cnum_mid;
    pch_mid = pressed[grmc_pkg::BTN_PCH_DOWN] ? grmc_pkg::sat_down(pch_q) : pch_q;
    pch_mid = pressed[grmc_pkg::BTN_PCH_UP] ? grmc_pkg::sat_up(pch_mid) : pch_mid;
    pval_dn = pressed[grmc_pkg::BTN_PVAL_DOWN] ? grmc_pkg::sat_down(pval_q) : pval_q;
    pval_up = pressed[grmc_pkg::BTN_PVAL_UP] ? grmc_pkg::sat_up(pval_dn) : pval_dn;

    // Clear buttons act last, after the packets have taken their values
    cch_d  = pressed[grmc_pkg::BTN_CTRL_CLR] ? 7'd0 : cch_mid;
    cnum_d = pressed[grmc_pkg::BTN_CTRL_CLR] ? 7'd0 : cnum_mid;
    cval_d = pressed[grmc_pkg::BTN_CTRL_CLR] ? 7'd0 : cval_step;
    pch_d  = pressed[grmc_pkg::BTN_PROG_CLR] ? 7'd0 : pch_mid;
    pval_d = pressed[grmc_pkg::BTN_PROG_CLR] ? 7'd0 : pval_up;
  end

  always_comb begin
    pkts_o.valid[0] = cc_fire;
    pkts_o.valid[1] = pressed[grmc_pkg::BTN_PVAL_DOWN];
    pkts_o.valid[2] = pressed[grmc_pkg::BTN_PVAL_UP];

    pkts_o.pkt[0].cable_code  = grmc_pkg::CIN_CTRL_CHANGE;
    pkts_o.pkt[0].status_byte = grmc_pkg::STATUS_CTRL | {1'b0, cch_q};
    pkts_o.pkt[0].data_first  = cnum_q;
    pkts_o.pkt[0].data_second = cval_step;

    pkts_o.pkt[1].cable_code  = grmc_pkg::CIN_PROG_CHANGE;
    pkts_o.pkt[1].status_byte = grmc_pkg::STATUS_PROG | {1'b0, pch_mid};
    pkts_o.pkt[1].data_first  = pval_dn;
    pkts_o.pkt[1].data_second = 7'd0;

    pkts_o.pkt[2].cable_code  = grmc_pkg::CIN_PROG_CHANGE;
    pkts_o.pkt[2].status_byte = grmc_pkg::STATUS_PROG | {1'b0, pch_mid};
    pkts_o.pkt[2].data_first  = pval_up;
    pkts_o.pkt[2].data_second = 7'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAD_BYTES; i++) begin
        pad_q[i] <= grmc_pkg::PAD_RESET;
      end
      buttons_q <= '0;
      pch_q     <= '0;
      pval_q    <= '0;
      cch_q     <= '0;
      cnum_q    <= '0;
      cval_q    <= '0;
    end else if (advance_i) begin
      if (differs) begin
        for (int i = 0; i < PAD_BYTES; i++) begin
          pad_q[i] <= in_bytes[i];
        end
      end
      buttons_q <= buttons;
      pch_q     <= pch_d;
      pval_q    <= pval_d;
      cch_q     <= cch_d;
      cnum_q    <= cnum_d;
      cval_q    <= cval_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grmc_pkt_queue.sv =====
// Result register holding up to three packets of one report, sent out in order.
`default_nettype none

module grmc_pkt_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  grmc_pkg::pkt_set_t  pkts_i,
  output logic                free_o,
  output logic                tvalid_o,
  input  wire                 tready_i,
  output grmc_pkg::packet_t   pkt_o,
  output logic                tlast_o
);

  logic [grmc_pkg::PKT_SLOTS-1:0] valid_q, valid_d;
  grmc_pkg::packet_t [grmc_pkg::PKT_SLOTS-1:0] pkt_q;
  logic [grmc_pkg::PKT_SLOTS-1:0] lowest;
  logic [grmc_pkg::PKT_SLOTS-1:0] rest;
  logic pop;

  assign lowest   = valid_q & (~valid_q + {{(grmc_pkg::PKT_SLOTS-1){1'b0}}, 1'b1});
  assign rest     = valid_q & ~lowest;
  assign tvalid_o = |valid_q;
  assign tlast_o  = (rest == '0);
  assign pop      = tvalid_o && tready_i;
  assign free_o   = !tvalid_o || (pop && tlast_o);

  always_comb begin
    pkt_o = pkt_q[grmc_pkg::PKT_SLOTS-1];
    for (int i = grmc_pkg::PKT_SLOTS - 1; i >= 0; i--) begin
      if (lowest[i]) begin
        pkt_o = pkt_q[i];
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (pop) begin
      valid_d = rest;
    end
    if (load_i) begin
      valid_d = pkts_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pkt_q <= pkts_i.pkt;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/gamepad_report_to_midi_controller_unit_tb.sv =====
// Self-checking testbench for the gamepad report to USB-MIDI packet unit.
`timescale 1ns / 1ps

module gamepad_report_to_midi_controller_unit_tb;

  localparam int unsigned PAD_BYTES    = 5;
  localparam int unsigned BUTTON_COUNT = 12;
  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned CLIMB_ITEMS  = 256;
  localparam logic [31:0] PAD_FILL     = {4{grmc_pkg::PAD_RESET}};
  localparam logic [11:0] CLIMB_MASK   = (12'd1 << grmc_pkg::BTN_CCH_UP) |
                                         (12'd1 << grmc_pkg::BTN_CNUM_UP) |
                                         (12'd1 << grmc_pkg::BTN_PCH_UP) |
                                         (12'd1 << grmc_pkg::BTN_PVAL_UP);

  typedef struct packed {
    logic              last;
    grmc_pkg::packet_t pkt;
  } midi_item_t;

  // typed = 1: the packets below are the expectation, else the predictor's output is
  typedef struct packed {
    grmc_pkg::report_t rep;
    logic              typed;
    logic [1:0]        n;
    midi_item_t [2:0]  pk;
  } step_row_t;

  localparam midi_item_t NO_PKT = '0;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic [55:0] s_data   = '0;
  logic        m_ready  = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [31:0] m_axis_tdata;
  wire         m_axis_tlast;

  // Controller state as the block should hold it
  logic [7:0]  pad_copy [PAD_BYTES] = '{default: grmc_pkg::PAD_RESET};
  logic [11:0] button_copy = '0;
  logic [6:0]  prog_chan = '0;
  logic [6:0]  prog_val  = '0;
  logic [6:0]  ctrl_chan = '0;
  logic [6:0]  ctrl_num  = '0;
  logic [6:0]  ctrl_val  = '0;

  midi_item_t  packets_due [$];
  int unsigned mismatches  = 0;
  bit          source_calm = 1'b0;
  bit          sink_calm   = 1'b0;

  always #5 clk_i = ~clk_i;

  gamepad_report_to_midi_controller_unit #(
    .PAD_BYTES    (PAD_BYTES),
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [6:0] nudge(input logic [6:0] v, input bit up);
    if (up) return (v == grmc_pkg::VALUE_MAX) ? v : v + 7'd1;
    return (v == 7'd0) ? v : v - 7'd1;
  endfunction

  function automatic midi_item_t mk_packet(input logic [3:0] code, input logic [7:0] status,
                                           input logic [6:0] d1, input logic [6:0] d2,
                                           input logic last);
    midi_item_t p;
    p.pkt.cable_code  = code;
    p.pkt.status_byte = status;
    p.pkt.data_first  = d1;
    p.pkt.data_second = d2;
    p.last            = last;
    return p;
  endfunction

  function automatic grmc_pkg::report_t make_report(input logic [7:0] axis,
                                                    input logic [31:0] bytes_1to4,
                                                    input logic [3:0] hat,
                                                    input logic [11:0] buttons);
    grmc_pkg::report_t r;
    r.axis_x = axis;
    {r.report_byte4, r.report_byte3, r.report_byte2, r.report_byte1} = bytes_1to4;
    r.hat_and_low_buttons = {buttons[3:0], hat};
    r.high_buttons        = buttons[11:4];
    return r;
  endfunction

  function automatic step_row_t table_row(input grmc_pkg::report_t r, input logic typed,
                                          input logic [1:0] n, input midi_item_t p);
    step_row_t row;
    row.rep   = r;
    row.typed = typed;
    row.n     = n;
    row.pk    = '0;
    row.pk[0] = p;
    return row;
  endfunction

  // Advance the controller by one report and return the packets it sends
  function automatic int unsigned translate_report(input grmc_pkg::report_t r,
                                                   output midi_item_t [2:0] pk);
    logic        differs;
    logic [11:0] held;
    logic [11:0] fresh;
    int unsigned n;
    n       = 0;
    pk      = '0;
    differs = 1'b0;
    for (int i = 0; i < PAD_BYTES; i++)
      if (r[8*i +: 8] != pad_copy[i]) differs = 1'b1;
    if (differs) begin
      for (int i = 0; i < PAD_BYTES; i++) pad_copy[i] = r[8*i +: 8];
      if (r.axis_x == grmc_pkg::AXIS_LOW || r.axis_x == grmc_pkg::AXIS_HIGH) begin
        ctrl_val = nudge(ctrl_val, r.axis_x == grmc_pkg::AXIS_HIGH);
        pk[n] = mk_packet(grmc_pkg::CIN_CTRL_CHANGE, grmc_pkg::STATUS_CTRL | {1'b0, ctrl_chan},
                          ctrl_num, ctrl_val, 1'b0);
        n++;
      end
    end
    held        = {r.high_buttons, r.hat_and_low_buttons[7:4]};
    fresh       = held & ~button_copy;
    button_copy = held;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      if (fresh[b]) begin
        case (b)
          grmc_pkg::BTN_CCH_DOWN:  ctrl_chan = nudge(ctrl_chan, 1'b0);
          grmc_pkg::BTN_CCH_UP:    ctrl_chan = nudge(ctrl_chan, 1'b1);
          grmc_pkg::BTN_CNUM_UP:   ctrl_num  = nudge(ctrl_num, 1'b1);
          grmc_pkg::BTN_CNUM_DOWN: ctrl_num  = nudge(ctrl_num, 1'b0);
          grmc_pkg::BTN_PCH_DOWN:  prog_chan = nudge(prog_chan, 1'b0);
          grmc_pkg::BTN_PCH_UP:    prog_chan = nudge(prog_chan, 1'b1);
          grmc_pkg::BTN_PVAL_DOWN, grmc_pkg::BTN_PVAL_UP: begin
            prog_val = nudge(prog_val, b == grmc_pkg::BTN_PVAL_UP);
            pk[n] = mk_packet(grmc_pkg::CIN_PROG_CHANGE,
                              grmc_pkg::STATUS_PROG | {1'b0, prog_chan}, prog_val,
                              7'd0, 1'b0);
            n++;
          end
          grmc_pkg::BTN_PROG_CLR: begin
            prog_chan = '0;
            prog_val  = '0;
          end
          grmc_pkg::BTN_CTRL_CLR: begin
            ctrl_chan = '0;
            ctrl_num  = '0;
            ctrl_val  = '0;
          end
          default: ;
        endcase
      end
    end
    if (n > 0) pk[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_report(input step_row_t row);
    int unsigned      gap;
    int unsigned      n;
    midi_item_t [2:0] pk;
    if ($urandom_range(0, 31) == 0) source_calm = !source_calm;
    gap = source_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= row.rep;
    do @(posedge clk_i); while (!s_axis_tready);
    n = translate_report(row.rep, pk);
    if (row.typed) begin
      n  = row.n;
      pk = row.pk;
    end
    for (int i = 0; i < n; i++) packets_due.push_back(pk[i]);
  endtask

  task automatic wait_drained();
    while (packets_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin : report_source
    step_row_t         script [$];
    grmc_pkg::report_t rep;
    grmc_pkg::report_t prev_rep;
    logic [63:0]       raw;
    logic [11:0]       mask;
    logic [11:0]       extra;
    logic [31:0]       filler;
    int unsigned       sent;
    int unsigned       len;
    int unsigned       kind;
    int unsigned       seq;
    bit                climbed;

    // Pad bytes unchanged from reset
    script.push_back(table_row(make_report(grmc_pkg::PAD_RESET, PAD_FILL, 4'h0, '0),
                     1'b1, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(grmc_pkg::AXIS_HIGH, PAD_FILL, 4'h0, '0),
                     1'b1, 2'd1,
                     mk_packet(grmc_pkg::CIN_CTRL_CHANGE, grmc_pkg::STATUS_CTRL, 7'd0, 7'd1,
                               1'b1)));
    // Same report at an axis extreme: no step
    script.push_back(table_row(make_report(grmc_pkg::AXIS_HIGH, PAD_FILL, 4'h0, '0),
                     1'b1, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(grmc_pkg::AXIS_LOW, PAD_FILL, 4'h0, '0),
                     1'b1, 2'd1,
                     mk_packet(grmc_pkg::CIN_CTRL_CHANGE, grmc_pkg::STATUS_CTRL, 7'd0, 7'd0,
                               1'b1)));
    // Control value saturates at zero
    script.push_back(table_row(make_report(grmc_pkg::AXIS_LOW, 32'h0D0D0DFF, 4'h0, '0),
                     1'b1, 2'd1,
                     mk_packet(grmc_pkg::CIN_CTRL_CHANGE, grmc_pkg::STATUS_CTRL, 7'd0, 7'd0,
                               1'b1)));
    script.push_back(table_row(make_report(8'h80, 32'h0D0D0DFF, 4'hF, '0),
                     1'b1, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(8'h80, 32'h0D0D0DFF, 4'hF,
                     12'd1 << grmc_pkg::BTN_PVAL_UP), 1'b1, 2'd1,
                     mk_packet(grmc_pkg::CIN_PROG_CHANGE, grmc_pkg::STATUS_PROG, 7'd1, 7'd0,
                               1'b1)));
    script.push_back(table_row(make_report(8'h80, 32'h0D0D0DFF, 4'hF,
                     (12'd1 << grmc_pkg::BTN_PVAL_UP) | (12'd1 << grmc_pkg::BTN_PVAL_DOWN)),
                     1'b1, 2'd1,
                     mk_packet(grmc_pkg::CIN_PROG_CHANGE, grmc_pkg::STATUS_PROG, 7'd0, 7'd0,
                               1'b1)));
    script.push_back(table_row(make_report(8'h80, 32'h0D0D0DFF, 4'hF, '0),
                     1'b1, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(8'h80, 32'h0D0D0DFF, 4'hF,
                     12'd1 << grmc_pkg::BTN_PVAL_DOWN), 1'b1, 2'd1,
                     mk_packet(grmc_pkg::CIN_PROG_CHANGE, grmc_pkg::STATUS_PROG, 7'd0, 7'd0,
                               1'b1)));
    // Hat nibble only
    script.push_back(table_row(make_report(8'h80, 32'h0D0D0DFF, 4'h5, '0),
                     1'b1, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(8'h80, 32'h0D0D0DFF, 4'h5, 12'hC00),
                     1'b1, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(8'h80, 32'h0D0D0DFF, 4'h5, '0),
                     1'b1, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(grmc_pkg::AXIS_HIGH, 32'h0D0D0DFF, 4'hA, 12'hFFF),
                     1'b0, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(grmc_pkg::AXIS_HIGH, 32'h0D0D0DFF, 4'hA, '0),
                     1'b0, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(grmc_pkg::AXIS_HIGH, 32'h0D0D11FF, 4'h0,
                     12'd1 << grmc_pkg::BTN_CCH_UP), 1'b0, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(grmc_pkg::AXIS_HIGH, 32'h0D0D12FF, 4'h0, '0),
                     1'b0, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(grmc_pkg::AXIS_LOW, 32'h0D0D12FF, 4'h0,
                     (12'd1 << grmc_pkg::BTN_PCH_UP) | (12'd1 << grmc_pkg::BTN_PVAL_UP)),
                     1'b0, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(grmc_pkg::AXIS_LOW, 32'h0D0D12FF, 4'h0,
                     (12'd1 << grmc_pkg::BTN_PROG_CLR) | (12'd1 << grmc_pkg::BTN_CTRL_CLR)),
                     1'b0, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(grmc_pkg::AXIS_HIGH, 32'hFFFFFFFF, 4'hF, 12'hFFF),
                     1'b0, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(grmc_pkg::AXIS_LOW, 32'h00000000, 4'h0, '0),
                     1'b0, 2'd0, NO_PKT));
    script.push_back(table_row(make_report(8'h7F, 32'h5A5AA5A5, 4'h0, 12'h00F),
                     1'b0, 2'd0, NO_PKT));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) send_report(script[i]);
    s_valid <= 1'b0;
    wait_drained();

    sent     = 0;
    seq      = 0;
    climbed  = 1'b0;
    prev_rep = script[script.size()-1].rep;
    while (sent < RANDOM_ITEMS) begin
      if (!climbed && sent >= 8) begin
        // Tap every up button with X at its high extreme and fresh pad bytes each item: drive all values to 127
        for (int k = 0; k < CLIMB_ITEMS; k++) begin
          extra  = {2'($urandom_range(0, 3)), 10'h000};
          mask   = k[0] ? extra : (CLIMB_MASK | extra);
          filler = {16'($urandom), 16'(seq)};
          seq++;
          rep = make_report(grmc_pkg::AXIS_HIGH, filler, 4'($urandom), mask);
          send_report(table_row(rep, 1'b0, 2'd0, NO_PKT));
        end
        prev_rep = rep;
        sent    += CLIMB_ITEMS;
        climbed  = 1'b1;
        // Hold off until the output side is empty
        s_valid <= 1'b0;
        wait_drained();
      end else begin
        kind = $urandom_range(0, 9);
        len  = $urandom_range(4, 20);
        mask = '0;
        repeat ($urandom_range(1, 3)) mask[$urandom_range(0, 11)] = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (kind < 4) begin
            raw = {$urandom, $urandom};
            rep = raw[55:0];
            if ($urandom_range(0, 2) == 0) rep[39:0] = prev_rep[39:0];
            if ($urandom_range(0, 3) == 0)
              rep.axis_x = $urandom_range(0, 1) ? grmc_pkg::AXIS_HIGH : grmc_pkg::AXIS_LOW;
          end else begin
            // Press and release the same buttons; pad held or swept at an extreme
            filler = {16'($urandom), 16'(seq)};
            seq++;
            case (kind % 3)
              0:       rep = make_report(prev_rep.axis_x, prev_rep[39:8], 4'($urandom),
                                         k[0] ? 12'h000 : mask);
              1:       rep = make_report(grmc_pkg::AXIS_HIGH, filler, 4'($urandom),
                                         k[0] ? 12'h000 : mask);
              default: rep = make_report(grmc_pkg::AXIS_LOW, filler, 4'($urandom),
                                         k[0] ? 12'h000 : mask);
            endcase
          end
          send_report(table_row(rep, 1'b0, 2'd0, NO_PKT));
          prev_rep = rep;
        end
        sent += len;
      end
    end
    s_valid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && packets_due.size() == 0) begin
      $display("gamepad_report_to_midi_controller_unit_tb: done, clean");
    end else begin
      $display("gamepad_report_to_midi_controller_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin : packet_sink
    midi_item_t        want;
    grmc_pkg::packet_t got;
    int unsigned       stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata[25:0];
      if (packets_due.size() == 0) begin
        $error("packet with nothing due: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = packets_due.pop_front();
        check_field("cable_code", 8'(want.pkt.cable_code), 8'(got.cable_code));
        check_field("status_byte", want.pkt.status_byte, got.status_byte);
        check_field("data_first", 8'(want.pkt.data_first), 8'(got.data_first));
        check_field("data_second", 8'(want.pkt.data_second), 8'(got.data_second));
        check_field("tlast", 8'(want.last), 8'(m_axis_tlast));
        check_field("tdata padding", 8'h00, 8'(m_axis_tdata[31:26]));
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("gamepad_report_to_midi_controller_unit_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/grmc_pkg.sv
rtl/grmc_step.sv
rtl/grmc_pkt_queue.sv
rtl/gamepad_report_to_midi_controller_unit.sv
tb/sv/gamepad_report_to_midi_controller_unit_tb.sv
